### sv/srgb_lp_pkg.sv
// Shared types, constants and elaboration-time tables for the sRGB linearize unit.
package srgb_lp_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int FRAC_BITS = 24;
   localparam int QW = FRAC_BITS + 1;
   localparam int NUM_CODES = 1 << SAMPLE_BITS;
   localparam int FULL_SCALE = NUM_CODES - 1;
   localparam int LIN_KNEE = 678638;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PREMULTIPLY = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINEARIZE = 2'd2;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [QW-1:0] q_type;
   typedef q_type q_table_type [NUM_CODES];

   typedef struct packed {
      sample_type red;
      sample_type green;
      sample_type blue;
      sample_type alpha;
      logic partial;
      logic premultiply;
      logic linearize;
      logic last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> FRAC_BITS;
   endfunction

   function automatic logic [63:0] fifth_power(logic [63:0] r);
      logic [63:0] r2;
      logic [63:0] r4;
      r2 = qmul(r, r);
      r4 = qmul(r2, r2);
      return qmul(r4, r);
   endfunction

   function automatic logic [63:0] srgb_decode(logic [63:0] s);
      logic [63:0] b;
      logic [63:0] b2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      if (s <= 64'(LIN_KNEE)) begin
         return (s * 64'd25) / 64'd323;
      end
      b = (s * 64'd1000 + 64'd55 * (64'd1 << FRAC_BITS)) / 64'd1055;
      if (b > (64'd1 << FRAC_BITS)) begin
         b = 64'd1 << FRAC_BITS;
      end
      b2 = qmul(b, b);
      lo = 64'd0;
      hi = 64'd1 << FRAC_BITS;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         if (fifth_power(mid) <= b2) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return qmul(b2, lo);
   endfunction

   function automatic logic [63:0] curve_code(logic [63:0] s);
      return (srgb_decode(s) * 64'(FULL_SCALE)) >> FRAC_BITS;
   endfunction

   function automatic q_table_type build_norm_table();
      q_table_type t;
      for (int i = 0; i < NUM_CODES; i++) begin
         t[i] = QW'((64'(i) * (64'd1 << FRAC_BITS) + 64'(FULL_SCALE) - 64'd1)
                    / 64'(FULL_SCALE));
      end
      return t;
   endfunction

   // smallest Q1.24 input whose decoded output code reaches k
   function automatic q_table_type build_thresh_table();
      q_table_type t;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      t[0] = '0;
      for (int k = 1; k < NUM_CODES; k++) begin
         lo = 64'd0;
         hi = 64'd1 << FRAC_BITS;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (curve_code(mid) >= 64'(k)) begin
               hi = mid;
            end else begin
               lo = mid + 64'd1;
            end
         end
         t[k] = QW'(lo);
      end
      return t;
   endfunction

   localparam q_table_type NORM_TABLE = build_norm_table();
   localparam q_table_type THRESH_TABLE = build_thresh_table();

endpackage

### sv/srgb_lp_front.sv
// Front end: configuration registers, beat acceptance and pixel classification.
module srgb_lp_front
   import srgb_lp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  sample_type req_red_in,
   input  sample_type req_green_in,
   input  sample_type req_blue_in,
   input  sample_type req_alpha_in,
   input  logic req_last_pixel,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   input  queue_status_type q_status,
   output logic push,
   output item_type push_item
);

   logic [2:0] chan_ff, chan_in;
   logic premult_ff, premult_in;
   logic lin_ff, lin_in;
   logic four, use_green, use_blue;

   assign csr_ready = 1'b1;

   always_comb begin
      chan_in = chan_ff;
      premult_in = premult_ff;
      lin_in = lin_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: chan_in = csr_data;
            REG_PREMULTIPLY: premult_in = csr_data[0];
            REG_LINEARIZE: lin_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 3'd4;
         premult_ff <= 1'b1;
         lin_ff <= 1'b1;
      end else begin
         chan_ff <= chan_in;
         premult_ff <= premult_in;
         lin_ff <= lin_in;
      end
   end

   assign four = (chan_ff >= 3'd4);
   assign use_green = (chan_ff >= 3'd2);
   assign use_blue = (chan_ff >= 3'd3);

   assign req_stall = q_status.full;
   assign push = req_valid && !q_status.full;

   always_comb begin
      push_item.red = req_red_in;
      push_item.green = use_green ? req_green_in : '0;
      push_item.blue = use_blue ? req_blue_in : '0;
      push_item.alpha = four ? req_alpha_in : '0;
      push_item.partial = four && (req_alpha_in != sample_type'(FULL_SCALE));
      push_item.premultiply = four && premult_ff;
      push_item.linearize = lin_ff;
      push_item.last = req_last_pixel;
   end

endmodule

### sv/srgb_lp_queue.sv
// Small FIFO between the front end and the conversion pipeline.
module srgb_lp_queue
   import srgb_lp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  item_type push_item,
   input  logic pop,
   output item_type head,
   output queue_status_type q_status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign q_status.full = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/srgb_lp_back.sv
// Conversion pipeline: normalize, premultiply, decode threshold search or rescale, output.
module srgb_lp_back
   import srgb_lp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  item_type head,
   input  queue_status_type q_status,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output sample_type rsp_red_out,
   output sample_type rsp_green_out,
   output sample_type rsp_blue_out,
   output sample_type rsp_alpha_out,
   output logic rsp_alpha_not_full,
   output logic rsp_last_out
);

   localparam int STEPS = SAMPLE_BITS;

   typedef struct packed {
      logic [2:0][QW-1:0] s;
      logic [2:0][SAMPLE_BITS-1:0] k;
      sample_type alpha;
      logic partial;
      logic linearize;
      logic last;
   } work_type;

   logic advance;

   logic a_valid_ff;
   logic [2:0][QW-1:0] a_s_ff;
   q_type a_alpha_q_ff;
   logic a_premult_ff;
   sample_type a_alpha_ff;
   logic a_partial_ff, a_lin_ff, a_last_ff;

   logic [STEPS:0] w_valid_ff;
   work_type w_ff [STEPS+1];
   work_type w_in [STEPS+1];

   logic rsp_valid_ff;
   sample_type [2:0] color_ff;
   sample_type alpha_ff;
   logic not_full_ff, last_ff;
   sample_type [2:0] color_in;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop = advance && !q_status.empty;

   always_ff @(posedge clock) begin
      if (advance) begin
         a_s_ff[0] <= NORM_TABLE[head.red];
         a_s_ff[1] <= NORM_TABLE[head.green];
         a_s_ff[2] <= NORM_TABLE[head.blue];
         a_alpha_q_ff <= head.partial ? NORM_TABLE[head.alpha] : q_type'(1 << FRAC_BITS);
         a_premult_ff <= head.premultiply;
         a_alpha_ff <= head.alpha;
         a_partial_ff <= head.partial;
         a_lin_ff <= head.linearize;
         a_last_ff <= head.last;
      end
   end

   always_comb begin
      logic [2*QW-1:0] prod;
      w_in[0] = '0;
      for (int c = 0; c < 3; c++) begin
         prod = a_s_ff[c] * a_alpha_q_ff;
         w_in[0].s[c] = a_premult_ff ? prod[FRAC_BITS +: QW] : a_s_ff[c];
      end
      w_in[0].alpha = a_alpha_ff;
      w_in[0].partial = a_partial_ff;
      w_in[0].linearize = a_lin_ff;
      w_in[0].last = a_last_ff;
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_search
      localparam logic [SAMPLE_BITS-1:0] BIT = SAMPLE_BITS'(1) << (STEPS - 1 - j);
      always_comb begin
         logic [SAMPLE_BITS-1:0] cand;
         w_in[j+1] = w_ff[j];
         for (int c = 0; c < 3; c++) begin
            cand = w_ff[j].k[c] | BIT;
            if (THRESH_TABLE[cand] <= w_ff[j].s[c]) begin
               w_in[j+1].k[c] = cand;
            end
         end
      end
   end

   always_comb begin
      logic [QW+SAMPLE_BITS-1:0] scaled;
      for (int c = 0; c < 3; c++) begin
         scaled = {w_ff[STEPS].s[c], SAMPLE_BITS'(0)} - (QW+SAMPLE_BITS)'(w_ff[STEPS].s[c]);
         color_in[c] = w_ff[STEPS].linearize ? w_ff[STEPS].k[c]
                                            : scaled[FRAC_BITS +: SAMPLE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j <= STEPS; j++) begin
            w_ff[j] <= w_in[j];
         end
         color_ff <= color_in;
         alpha_ff <= w_ff[STEPS].alpha;
         not_full_ff <= w_ff[STEPS].partial;
         last_ff <= w_ff[STEPS].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         w_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= !q_status.empty;
         w_valid_ff <= {w_valid_ff[STEPS-1:0], a_valid_ff};
         rsp_valid_ff <= w_valid_ff[STEPS];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red_out = color_ff[0];
   assign rsp_green_out = color_ff[1];
   assign rsp_blue_out = color_ff[2];
   assign rsp_alpha_out = alpha_ff;
   assign rsp_alpha_not_full = not_full_ff;
   assign rsp_last_out = last_ff;

endmodule

### sv/srgb_linearize_premultiply_unit.sv
// Top level of the sRGB linearize and alpha premultiply unit.
// A request beat passes the queue, normalize, premultiply, search and output registers; stalls hold it.
// Throughput: one pixel per cycle while rsp_stall is low, set by the fully pipelined eight-step threshold search.
// The queue holds QUEUE_DEPTH pixels so request intake continues while the response side stalls, until it is full.
// Reset: synchronous; registers return to 4 channels, premultiply on, linearize on,
// and the queue and pipeline are emptied.
module srgb_linearize_premultiply_unit
   import srgb_lp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  sample_type req_red_in,
   input  sample_type req_green_in,
   input  sample_type req_blue_in,
   input  sample_type req_alpha_in,
   input  logic req_last_pixel,
   output logic rsp_valid,
   input  logic rsp_stall,
   output sample_type rsp_red_out,
   output sample_type rsp_green_out,
   output sample_type rsp_blue_out,
   output sample_type rsp_alpha_out,
   output logic rsp_alpha_not_full,
   output logic rsp_last_out,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic push, pop;
   item_type push_item, head;
   queue_status_type q_status;

   srgb_lp_front u_front (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_red_in, .req_green_in, .req_blue_in, .req_alpha_in, .req_last_pixel,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .q_status, .push, .push_item
   );

   srgb_lp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_item, .pop, .head, .q_status
   );

   srgb_lp_back u_back (
      .clock, .reset, .head, .q_status, .pop,
      .rsp_valid, .rsp_stall,
      .rsp_red_out, .rsp_green_out, .rsp_blue_out, .rsp_alpha_out,
      .rsp_alpha_not_full, .rsp_last_out
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_partial_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alpha_not_full |-> rsp_alpha_out != sample_type'(FULL_SCALE))
      else $error("alpha flag set on full-scale alpha");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty queue");

endmodule

### sim/tb_srgb_linearize_premultiply_unit.sv
// Self-checking testbench for the sRGB linearize and alpha premultiply unit.
`timescale 1ns / 1ps

module tb_srgb_linearize_premultiply_unit;
   import srgb_lp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PHASES = 13;
   localparam int BEATS_PER_PHASE = 100;
   localparam logic [63:0] Q_ONE = 64'd1 << FRAC_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

   typedef struct {
      sample_type red;
      sample_type green;
      sample_type blue;
      sample_type alpha;
      logic last;
   } pixel_type;

   typedef struct {
      sample_type red;
      sample_type green;
      sample_type blue;
      sample_type alpha;
      logic alpha_not_full;
      logic last;
   } converted_type;

   typedef struct {
      pixel_type pix;
      logic known;
      converted_type res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type req_red_in = '0;
   sample_type req_green_in = '0;
   sample_type req_blue_in = '0;
   sample_type req_alpha_in = '0;
   logic req_last_pixel = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sample_type rsp_red_out;
   sample_type rsp_green_out;
   sample_type rsp_blue_out;
   sample_type rsp_alpha_out;
   logic rsp_alpha_not_full;
   logic rsp_last_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   logic [2:0] channel_count_m;
   logic premultiply_m;
   logic linearize_m;

   converted_type pending_pixels[$];
   int failures = 0;
   int idle_cycles = 0;
   bit no_idle = 0;

   srgb_linearize_premultiply_unit DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] q24_of(sample_type x);
      return (64'(x) * Q_ONE + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
   endfunction

   function automatic logic [63:0] q24_mul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> FRAC_BITS;
   endfunction

   function automatic logic [63:0] pow5_q24(logic [63:0] r);
      logic [63:0] sq;
      sq = q24_mul(r, r);
      return q24_mul(q24_mul(sq, sq), r);
   endfunction

   // decode curve; root is found by bitwise descent (p5 is monotone)
   function automatic logic [63:0] decode_srgb(logic [63:0] s);
      logic [63:0] b;
      logic [63:0] b2;
      logic [63:0] root;
      if (s <= 64'(LIN_KNEE)) return (s * 64'd25) / 64'd323;
      b = (s * 64'd1000 + 64'd55 * Q_ONE) / 64'd1055;
      if (b > Q_ONE) b = Q_ONE;
      b2 = q24_mul(b, b);
      root = 64'd0;
      for (int k = FRAC_BITS; k >= 0; k--) begin
         if (pow5_q24(root | (64'd1 << k)) <= b2) root = root | (64'd1 << k);
      end
      return q24_mul(b2, root);
   endfunction

   function automatic converted_type convert_pixel(pixel_type p);
      converted_type c;
      int ch;
      logic four;
      logic partial;
      logic [63:0] a;
      logic [63:0] s;
      sample_type src[3];
      sample_type dst[3];
      ch = (channel_count_m == 0) ? 1 : (channel_count_m > 4) ? 4 : int'(channel_count_m);
      four = (ch == 4);
      partial = four && (p.alpha != sample_type'(FULL_SCALE));
      a = partial ? q24_of(p.alpha) : Q_ONE;
      src = '{p.red, p.green, p.blue};
      for (int j = 0; j < 3; j++) begin
         dst[j] = '0;
         if (j < ch) begin
            s = q24_of(src[j]);
            if (premultiply_m && four) s = q24_mul(s, a);
            if (linearize_m) s = decode_srgb(s);
            dst[j] = sample_type'((s * 64'(FULL_SCALE)) >> FRAC_BITS);
         end
      end
      c.red = dst[0];
      c.green = dst[1];
      c.blue = dst[2];
      c.alpha = four ? p.alpha : '0;
      c.alpha_not_full = partial;
      c.last = p.last;
      return c;
   endfunction

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_CHANNEL_COUNT: channel_count_m = val;
         REG_PREMULTIPLY: premultiply_m = val[0];
         REG_LINEARIZE: linearize_m = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(pixel_type p, converted_type res);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= p.red;
      req_green_in <= p.green;
      req_blue_in <= p.blue;
      req_alpha_in <= p.alpha;
      req_last_pixel <= p.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(res);
   endtask

   function automatic sample_type rand_sample();
      case ($urandom_range(7))
         0: return '0;
         1: return sample_type'(FULL_SCALE);
         default: return sample_type'($urandom_range(FULL_SCALE));
      endcase
   endfunction

   // DUT response checker
   always @(posedge clock) begin
      converted_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected response beat");
            failures++;
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_red_out !== e.red) begin
               $error("red_out expected %0d got %0d", e.red, rsp_red_out);
               failures++;
            end
            if (rsp_green_out !== e.green) begin
               $error("green_out expected %0d got %0d", e.green, rsp_green_out);
               failures++;
            end
            if (rsp_blue_out !== e.blue) begin
               $error("blue_out expected %0d got %0d", e.blue, rsp_blue_out);
               failures++;
            end
            if (rsp_alpha_out !== e.alpha) begin
               $error("alpha_out expected %0d got %0d", e.alpha, rsp_alpha_out);
               failures++;
            end
            if (rsp_alpha_not_full !== e.alpha_not_full) begin
               $error("alpha_not_full expected %0d got %0d", e.alpha_not_full,
                      rsp_alpha_not_full);
               failures++;
            end
            if (rsp_last_out !== e.last) begin
               $error("last_out expected %0d got %0d", e.last, rsp_last_out);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      directed_row_type rows[];
      logic [2:0] chan_plan[RANDOM_PHASES];
      pixel_type p;
      rows = '{
         '{'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}},
         '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
           '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1}},
         '{'{8'd255, 8'd255, 8'd255, 8'd0, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}},
         '{'{8'd0, 8'd0, 8'd0, 8'd255, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0}},
         '{'{8'd10, 8'd11, 8'd12, 8'd255, 1'b0}, 1'b0, '{default: '0}},
         '{'{8'd100, 8'd150, 8'd200, 8'd255, 1'b0}, 1'b0, '{default: '0}},
         '{'{8'd255, 8'd128, 8'd1, 8'd128, 1'b0}, 1'b0, '{default: '0}},
         '{'{8'd170, 8'd85, 8'd254, 8'd254, 1'b0}, 1'b0, '{default: '0}},
         '{'{8'd85, 8'd170, 8'd1, 8'd1, 1'b0}, 1'b0, '{default: '0}},
         '{'{8'd170, 8'd85, 8'd128, 8'd85, 1'b1}, 1'b0, '{default: '0}},
         '{'{8'd127, 8'd128, 8'd254, 8'd170, 1'b0}, 1'b0, '{default: '0}}
      };
      chan_plan = '{3'd4, 3'd4, 3'd4, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7,
                    3'd4, 3'd4};
      channel_count_m = 3'd4;
      premultiply_m = 1'b1;
      linearize_m = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send_pixel(rows[i].pix, rows[i].known ? rows[i].res : convert_pixel(rows[i].pix));
      end
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         write_reg(REG_CHANNEL_COUNT, chan_plan[ph]);
         write_reg(REG_PREMULTIPLY, CSR_DATA_BITS'((ph < 4) ? ph[0] : $urandom_range(7)));
         write_reg(REG_LINEARIZE, CSR_DATA_BITS'((ph < 4) ? ph[1] : $urandom_range(7)));
         if (ph == 6) write_reg(REG_UNMAPPED, CSR_DATA_BITS'($urandom_range(7)));
         no_idle = (ph == 2);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if (ph == 5 && n == 50) wait_drained();
            p.red = rand_sample();
            p.green = rand_sample();
            p.blue = rand_sample();
            p.alpha = ($urandom_range(2) == 0) ? sample_type'(FULL_SCALE) : rand_sample();
            p.last = ($urandom_range(15) == 0);
            send_pixel(p, convert_pixel(p));
         end
      end
      no_idle = 0;
      wait_drained();
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
